// ----- hdl/dfr_pkg.sv -----
// Package for the datagram frame reassembler.
// Holds field widths, request and verdict codes, register indexes and reset values.
// No dependencies; every other file of the block imports it.
package dfr_pkg;

    // Field widths of the channels.
    localparam int REQ_W      = 2;
    localparam int ID_W       = 16;
    localparam int RAW_W      = 32;
    localparam int DLEN_W     = 11;
    localparam int BYTE_W     = 21;
    localparam int DROP_W     = 8;
    localparam int TICK_W     = 12;
    localparam int VERDICT_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 21;

    // Width used when datagram lengths are compared with the slice size.
    localparam int LEN_CMP_W  = 17;

    // Tag width of the slice-mark memory.
    localparam int EPOCH_W    = 8;

    // Request types.
    localparam logic [REQ_W-1:0] REQ_HDR  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TICK = 2'd1;
    localparam logic [REQ_W-1:0] REQ_END  = 2'd2;

    // Verdicts.
    localparam logic [VERDICT_W-1:0] V_DISCARD  = 3'd0;
    localparam logic [VERDICT_W-1:0] V_STORED   = 3'd1;
    localparam logic [VERDICT_W-1:0] V_COMPLETE = 3'd2;
    localparam logic [VERDICT_W-1:0] V_ERROR    = 3'd3;
    localparam logic [VERDICT_W-1:0] V_END      = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BUF_LEN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESYNC     = 2'd2;

    // Configuration reset values.
    localparam logic [BYTE_W-1:0] RST_BUF_LEN    = 21'd1499136;
    localparam logic [DROP_W-1:0] RST_DROP_LIMIT = 8'd16;
    localparam logic [TICK_W-1:0] RST_RESYNC     = 12'd2000;

    // Header bytes in each datagram and the idle counter ceiling.
    localparam int                HDR_BYTES = 6;
    localparam logic [TICK_W-1:0] IDLE_MAX  = 12'hFFF;

    // Control of the slice-mark store for one step.
    typedef struct packed {
        logic rd_en;    // read the mark of the addressed slice
        logic set;      // mark the addressed slice
        logic restart;  // a new frame begins, all marks are void
    } t_mark_ctl;

    // True when id a is not newer than id b in 16-bit serial order.
    function automatic logic not_newer(input logic [ID_W-1:0] a, input logic [ID_W-1:0] b);
        logic [ID_W-1:0] d;
        d = a - b;
        return (d == '0) || d[ID_W-1];
    endfunction

endpackage

// ----- hdl/dfr_channels.sv -----
// Channel interfaces of the datagram frame reassembler: header input,
// verdict output and configuration write.
// Depends on dfr_pkg for the field widths.

interface dfr_in_if import dfr_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [REQ_W-1:0]        req_type;
    logic                    from_peer;
    logic [ID_W-1:0]         frame_id;
    logic signed [RAW_W-1:0] slice_count;
    logic [DLEN_W-1:0]       datagram_len;

    modport source (output valid, req_type, from_peer, frame_id, slice_count, datagram_len,
                    input ready);
    modport sink   (input valid, req_type, from_peer, frame_id, slice_count, datagram_len,
                    output ready);
endinterface

interface dfr_out_if import dfr_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [VERDICT_W-1:0] verdict;
    logic [BYTE_W-1:0]    write_offset;
    logic [DLEN_W-1:0]    write_len;
    logic [BYTE_W-1:0]    frame_bytes;

    modport source (output valid, verdict, write_offset, write_len, frame_bytes,
                    input ready);
    modport sink   (input valid, verdict, write_offset, write_len, frame_bytes,
                    output ready);
endinterface

interface dfr_cfg_if import dfr_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- hdl/dfr_marks.sv -----
// Slice-mark store: one epoch tag per slice in a synchronous memory.
// A slice is marked when its tag equals the current epoch; a new frame bumps the epoch.
// Depends on dfr_pkg for the tag width and the control struct.
module dfr_marks import dfr_pkg::*; #(
    parameter int MAX_SLICES = 1024,
    localparam int IDX_W = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_mark_ctl        i_ctl,
    input  logic [IDX_W-1:0] i_addr,
    output logic             o_marked,
    output logic             o_busy
);

    logic [EPOCH_W-1:0] r_mem [MAX_SLICES];
    logic [EPOCH_W-1:0] r_q;
    logic [EPOCH_W-1:0] r_epoch, n_epoch;
    logic               r_sweep, n_sweep;
    logic [IDX_W-1:0]   r_sw_addr, n_sw_addr;
    logic               r_keep, n_keep;
    logic [IDX_W-1:0]   r_keep_addr, n_keep_addr;

    logic               w_wr_en;
    logic [IDX_W-1:0]   w_wr_addr;
    logic [EPOCH_W-1:0] w_wr_data;
    logic [EPOCH_W-1:0] w_next_epoch;
    logic               w_wrap;

    // Epoch zero is what the clearing pass writes, so live epochs run from one up.
    assign w_next_epoch = (r_epoch == '1) ? EPOCH_W'(1) : r_epoch + EPOCH_W'(1);
    assign w_wrap       = i_ctl.restart && (r_epoch == '1);

    // Sweep control and write port selection.  When the epoch wraps, every
    // tag is cleared so that no stale tag can match a reused epoch; a slice
    // marked by the restarting transaction is written during that pass.
    always_comb begin
        n_epoch     = r_epoch;
        n_sweep     = r_sweep;
        n_sw_addr   = r_sw_addr;
        n_keep      = r_keep;
        n_keep_addr = r_keep_addr;
        w_wr_en     = 1'b0;
        w_wr_addr   = i_addr;
        w_wr_data   = r_epoch;
        if (r_sweep) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_sw_addr;
            w_wr_data = (r_keep && (r_sw_addr == r_keep_addr)) ? r_epoch : '0;
            if (r_sw_addr == IDX_W'(MAX_SLICES - 1)) begin
                n_sweep = 1'b0;
            end else begin
                n_sw_addr = r_sw_addr + IDX_W'(1);
            end
        end else begin
            if (i_ctl.restart) begin
                n_epoch = w_next_epoch;
            end
            if (w_wrap) begin
                n_sweep     = 1'b1;
                n_sw_addr   = '0;
                n_keep      = i_ctl.set;
                n_keep_addr = i_addr;
            end else if (i_ctl.set) begin
                w_wr_en   = 1'b1;
                w_wr_data = i_ctl.restart ? w_next_epoch : r_epoch;
            end
        end
    end

    // Control registers; reset starts a clearing pass over the whole memory.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch     <= EPOCH_W'(1);
            r_sweep     <= 1'b1;
            r_sw_addr   <= '0;
            r_keep      <= 1'b0;
            r_keep_addr <= '0;
        end else begin
            r_epoch     <= n_epoch;
            r_sweep     <= n_sweep;
            r_sw_addr   <= n_sw_addr;
            r_keep      <= n_keep;
            r_keep_addr <= n_keep_addr;
        end
    end

    // Tag memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_q <= r_mem[i_addr];
        end
    end

    assign o_marked = (r_q == r_epoch);
    assign o_busy   = r_sweep;

endmodule

// ----- hdl/datagram_frame_reassembler_unit.sv -----
// Top level of the datagram frame reassembler.
// Depends on dfr_pkg, the channel interfaces in dfr_channels and the dfr_marks store.

// The block takes one request per transaction (datagram header, millisecond
// tick or end of stream) and gives at most one verdict transaction per request:
// discarded, slice stored with its byte offset and length, frame complete with
// the frame byte total, error, or end. A header goes through these steps from
// acceptance to its verdict: accept, evaluate and read the slice mark, multiply
// the slice number by the slice size, then check, write the mark back and
// register the verdict. Ticks, end requests and headers decided early finish
// at the evaluate step. The read-then-write of the slice-mark memory and the
// offset multiplier set these steps; only one request is in flight, so a mark
// written by one header is always in memory before the next header reads it.
// The output register lets a new request be accepted while a verdict waits; a
// verdict that cannot be registered stalls the request in flight. After reset
// the input stays not ready while the whole mark memory is cleared, and the
// same clearing pass follows every 255th frame start. Configuration writes are
// taken at any time and are meant for idle periods.
module datagram_frame_reassembler_unit import dfr_pkg::*; #(
    parameter int MAX_SLICES  = 1024,
    parameter int SLICE_BYTES = 1464
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dfr_in_if.sink     i_in,
    dfr_out_if.source  o_out,
    dfr_cfg_if.sink    i_cfg
);

    localparam int IDX_W  = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
    localparam int CNT_W  = $clog2(MAX_SLICES + 1);
    localparam int SB_W   = $clog2(SLICE_BYTES + 1);
    localparam int PROD_W = IDX_W + SB_W;
    localparam int CMP_W  = ((PROD_W > BYTE_W) ? PROD_W : BYTE_W) + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_MUL  = 2'd2;
    localparam logic [1:0] S_CHK  = 2'd3;

    // Control and configuration.
    logic [1:0]         r_state, n_state;
    logic [BYTE_W-1:0]  r_buf_len;
    logic [DROP_W-1:0]  r_drop_limit;
    logic [TICK_W-1:0]  r_resync;

    // Captured request.
    logic [REQ_W-1:0]   r_req;
    logic               r_peer;
    logic [ID_W-1:0]    r_fid;
    logic [RAW_W-1:0]   r_raw;
    logic [DLEN_W-1:0]  r_dlen;

    // Frame state.
    logic               r_in_frame, n_in_frame;
    logic [CNT_W-1:0]   r_exp_total, n_exp_total;
    logic [ID_W-1:0]    r_cur_id, n_cur_id;
    logic [CNT_W-1:0]   r_got, n_got;
    logic [DROP_W-1:0]  r_drop, n_drop;
    logic [BYTE_W-1:0]  r_high, n_high;
    logic [ID_W-1:0]    r_last_id, n_last_id;
    logic               r_last_valid, n_last_valid;
    logic [TICK_W-1:0]  r_idle, n_idle;

    // Header in flight between stages.
    logic               r_is_start, n_is_start;
    logic [IDX_W-1:0]   r_seq, n_seq;
    logic [CNT_W-1:0]   r_total, n_total;
    logic [DLEN_W-1:0]  r_size, n_size;
    logic               r_size_bad, n_size_bad;
    logic [PROD_W-1:0]  r_prod, n_prod;

    // Output register.
    logic                 r_out_valid, n_out_valid;
    logic [VERDICT_W-1:0] r_out_verdict, n_out_verdict;
    logic [BYTE_W-1:0]    r_out_off, n_out_off;
    logic [DLEN_W-1:0]    r_out_len, n_out_len;
    logic [BYTE_W-1:0]    r_out_bytes, n_out_bytes;

    // Combinational helpers.
    logic               w_in_acc;
    logic               w_out_free;
    logic               w_fail, w_disc, w_end;
    logic [DLEN_W-1:0]  w_size;
    logic [RAW_W-1:0]   w_neg_total;
    logic [DROP_W-1:0]  w_drop_inc;
    logic [IDX_W-1:0]   w_seq_calc;
    logic [IDX_W-1:0]   w_mul_a;
    logic [CMP_W-1:0]   w_pos, w_sz, w_buf, w_end_pos;
    logic [CNT_W-1:0]   w_got_next;
    logic [BYTE_W-1:0]  w_high_next;
    logic               w_marked;
    logic               w_busy;
    t_mark_ctl          w_ctl;
    logic [IDX_W-1:0]   w_mark_addr;

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;

    // Slice-mark store.
    dfr_marks #(
        .MAX_SLICES (MAX_SLICES)
    ) u_marks (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_addr   (w_mark_addr),
        .o_marked (w_marked),
        .o_busy   (w_busy)
    );

    // Values derived from the captured header.
    assign w_size      = r_dlen - DLEN_W'(HDR_BYTES);
    assign w_neg_total = (~r_raw) + RAW_W'(1);
    assign w_drop_inc  = r_drop + DROP_W'(1);
    assign w_seq_calc  = r_raw[RAW_W-1] ? '0 : IDX_W'(r_exp_total - CNT_W'(r_raw));
    assign w_mark_addr = (r_state == S_EVAL) ? w_seq_calc : r_seq;

    // Multiplier operand: for a start the limit check needs (total - 1) * size,
    // for a later slice the offset needs seq * size.
    assign w_mul_a = r_is_start ? IDX_W'(r_total - CNT_W'(1)) : r_seq;

    // Fit check and high mark arithmetic of the final stage.
    assign w_pos       = r_is_start ? '0 : CMP_W'(r_prod);
    assign w_sz        = CMP_W'(r_size);
    assign w_buf       = CMP_W'(r_buf_len);
    assign w_end_pos   = w_pos + w_sz;
    assign w_got_next  = (r_is_start ? '0 : r_got) + CNT_W'(1);
    assign w_high_next = (w_end_pos > CMP_W'(r_high)) ? BYTE_W'(w_end_pos) : r_high;

    // Request sequencing and state update.
    always_comb begin
        n_state       = r_state;
        n_in_frame    = r_in_frame;
        n_exp_total   = r_exp_total;
        n_cur_id      = r_cur_id;
        n_got         = r_got;
        n_drop        = r_drop;
        n_high        = r_high;
        n_last_id     = r_last_id;
        n_last_valid  = r_last_valid;
        n_idle        = r_idle;
        n_is_start    = r_is_start;
        n_seq         = r_seq;
        n_total       = r_total;
        n_size        = r_size;
        n_size_bad    = r_size_bad;
        n_prod        = r_prod;
        n_out_valid   = r_out_valid && !o_out.ready;
        n_out_verdict = r_out_verdict;
        n_out_off     = r_out_off;
        n_out_len     = r_out_len;
        n_out_bytes   = r_out_bytes;
        w_fail        = 1'b0;
        w_disc        = 1'b0;
        w_end         = 1'b0;
        w_ctl         = '0;

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = S_EVAL;
                end
            end

            // Early decisions; a header that survives reads its slice mark.
            S_EVAL: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                    case (r_req)
                        REQ_TICK: begin
                            n_idle = (r_idle != IDLE_MAX) ? r_idle + TICK_W'(1) : r_idle;
                            if (r_last_valid && (n_idle > r_resync)) begin
                                n_last_valid = 1'b0;
                            end
                        end
                        REQ_END: begin
                            w_end = 1'b1;
                        end
                        REQ_HDR: begin
                            if (r_buf_len == '0) begin
                                w_fail = 1'b1;
                            end else if (!r_peer) begin
                                w_disc = 1'b1;
                            end else if ((r_dlen < DLEN_W'(HDR_BYTES)) ||
                                         (LEN_CMP_W'(r_dlen) >
                                          LEN_CMP_W'(SLICE_BYTES + HDR_BYTES))) begin
                                w_fail = 1'b1;
                            end else if (r_raw[RAW_W-1]) begin
                                // Frame start.
                                if ((r_in_frame && not_newer(r_fid, r_cur_id)) ||
                                    (r_last_valid && not_newer(r_fid, r_last_id))) begin
                                    w_disc = 1'b1;
                                end else begin
                                    n_got    = '0;
                                    n_cur_id = r_fid;
                                    if (w_neg_total > RAW_W'(MAX_SLICES)) begin
                                        // Also covers the most negative count.
                                        w_fail = 1'b1;
                                    end else begin
                                        n_is_start  = 1'b1;
                                        n_total     = CNT_W'(w_neg_total);
                                        n_seq       = w_seq_calc;
                                        n_size      = w_size;
                                        n_size_bad  = (w_neg_total > RAW_W'(1)) &&
                                                      (LEN_CMP_W'(w_size) !=
                                                       LEN_CMP_W'(SLICE_BYTES));
                                        w_ctl.rd_en = 1'b1;
                                        n_state     = S_MUL;
                                    end
                                end
                            end else if (r_in_frame && (r_fid != r_cur_id)) begin
                                w_disc = 1'b1;
                            end else if (!r_in_frame) begin
                                // Header before any start.
                                n_drop = w_drop_inc;
                                if (w_drop_inc < r_drop_limit) begin
                                    w_disc = 1'b1;
                                end else begin
                                    w_fail = 1'b1;
                                end
                            end else if ((r_raw == '0) ||
                                         (r_raw > RAW_W'(r_exp_total))) begin
                                w_fail = 1'b1;
                            end else begin
                                n_is_start  = 1'b0;
                                n_total     = r_exp_total;
                                n_seq       = w_seq_calc;
                                n_size      = w_size;
                                n_size_bad  = (r_raw > RAW_W'(1)) &&
                                              (LEN_CMP_W'(w_size) !=
                                               LEN_CMP_W'(SLICE_BYTES));
                                w_ctl.rd_en = 1'b1;
                                n_state     = S_MUL;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // Offset or limit product.
            S_MUL: begin
                n_prod  = PROD_W'(w_mul_a) * PROD_W'(SLICE_BYTES);
                n_state = S_CHK;
            end

            // Final checks, mark write-back and verdict.
            S_CHK: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                    if (r_is_start && (CMP_W'(r_prod) >= w_buf)) begin
                        // More slices than the buffer can take.
                        w_fail = 1'b1;
                    end else begin
                        if (r_is_start) begin
                            n_in_frame    = 1'b1;
                            n_exp_total   = r_total;
                            w_ctl.restart = 1'b1;
                        end
                        if (r_size_bad || (w_sz > w_buf) || (w_pos > w_buf - w_sz)) begin
                            w_fail = 1'b1;
                        end else if (!r_is_start && w_marked) begin
                            w_disc = 1'b1;
                        end else begin
                            w_ctl.set   = 1'b1;
                            n_out_valid = 1'b1;
                            n_out_off   = BYTE_W'(w_pos);
                            n_out_len   = r_size;
                            if (w_got_next >= r_total) begin
                                n_out_verdict = V_COMPLETE;
                                n_out_bytes   = w_high_next;
                                n_last_id     = r_cur_id;
                                n_last_valid  = 1'b1;
                                n_idle        = '0;
                                n_in_frame    = 1'b0;
                                n_got         = '0;
                                n_drop        = '0;
                                n_high        = '0;
                            end else begin
                                n_out_verdict = V_STORED;
                                n_out_bytes   = '0;
                                n_got         = w_got_next;
                                n_high        = w_high_next;
                            end
                        end
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Terminating verdicts close the call.
        if (w_fail || w_end) begin
            n_in_frame = 1'b0;
            n_got      = '0;
            n_drop     = '0;
            n_high     = '0;
        end
        if (w_fail || w_disc || w_end) begin
            n_out_valid   = 1'b1;
            n_out_off     = '0;
            n_out_len     = '0;
            n_out_bytes   = '0;
            n_out_verdict = w_fail ? V_ERROR : (w_end ? V_END : V_DISCARD);
        end
    end

    // Control and frame state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_in_frame   <= 1'b0;
            r_exp_total  <= '0;
            r_cur_id     <= '0;
            r_got        <= '0;
            r_drop       <= '0;
            r_high       <= '0;
            r_last_id    <= '0;
            r_last_valid <= 1'b0;
            r_idle       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_in_frame   <= n_in_frame;
            r_exp_total  <= n_exp_total;
            r_cur_id     <= n_cur_id;
            r_got        <= n_got;
            r_drop       <= n_drop;
            r_high       <= n_high;
            r_last_id    <= n_last_id;
            r_last_valid <= n_last_valid;
            r_idle       <= n_idle;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers: captured request, stage data and verdict fields.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_req  <= i_in.req_type;
            r_peer <= i_in.from_peer;
            r_fid  <= i_in.frame_id;
            r_raw  <= $unsigned(i_in.slice_count);
            r_dlen <= i_in.datagram_len;
        end
        r_is_start    <= n_is_start;
        r_seq         <= n_seq;
        r_total       <= n_total;
        r_size        <= n_size;
        r_size_bad    <= n_size_bad;
        r_prod        <= n_prod;
        r_out_verdict <= n_out_verdict;
        r_out_off     <= n_out_off;
        r_out_len     <= n_out_len;
        r_out_bytes   <= n_out_bytes;
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_len    <= RST_BUF_LEN;
            r_drop_limit <= RST_DROP_LIMIT;
            r_resync     <= RST_RESYNC;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_BUF_LEN:    r_buf_len    <= i_cfg.data[BYTE_W-1:0];
                CFG_DROP_LIMIT: r_drop_limit <= i_cfg.data[DROP_W-1:0];
                CFG_RESYNC:     r_resync     <= i_cfg.data[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Ports.
    assign i_in.ready         = (r_state == S_IDLE) && !w_busy;
    assign i_cfg.ready        = 1'b1;
    assign o_out.valid        = r_out_valid;
    assign o_out.verdict      = r_out_verdict;
    assign o_out.write_offset = r_out_off;
    assign o_out.write_len    = r_out_len;
    assign o_out.frame_bytes  = r_out_bytes;

`ifndef ASSERT_OFF
    // Only one request is in flight at a time.
    a_single_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("request accepted while another is in flight");

    // An open frame always has a slice total within the mark store.
    a_frame_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_frame |-> ((r_exp_total != '0) && (r_exp_total <= CNT_W'(MAX_SLICES))))
        else $error("open frame with an impossible slice total");

    // An open frame never holds all of its slices.
    a_got_below_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_frame |-> (r_got < r_exp_total))
        else $error("open frame already holds all of its slices");

    // No request is taken while the mark memory is being cleared.
    a_sweep_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !i_in.ready)
        else $error("request accepted during the mark clearing pass");
`endif

endmodule

// ----- tb/dfr_checker.sv -----
`timescale 1ns / 1ps
// Verdict checker for the datagram frame reassembler testbench.
// Watches the request, verdict and configuration channels, predicts each verdict and compares.
// Depends on dfr_pkg and the channel interfaces of dfr_channels.
module dfr_checker import dfr_pkg::*; #(
    parameter int MAX_SLICES  = 1024,
    parameter int SLICE_BYTES = 1464
) (
    input  logic i_clk,
    input  logic i_rst_n,
    dfr_in_if    i_in,
    dfr_out_if   i_out,
    dfr_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending
);

    localparam logic [RAW_W-1:0] INT_MIN_BITS = 32'h8000_0000;

    typedef struct packed {
        logic [VERDICT_W-1:0] verdict;
        logic [BYTE_W-1:0]    write_offset;
        logic [DLEN_W-1:0]    write_len;
        logic [BYTE_W-1:0]    frame_bytes;
    } verdict_t;

    // Shadow copies of the configuration registers.
    logic [BYTE_W-1:0] buf_len;
    logic [DROP_W-1:0] drop_limit;
    logic [TICK_W-1:0] resync_ticks;

    // Shadow copy of the reassembly state.
    logic                  in_frame;
    longint                expected_total;
    logic [ID_W-1:0]       current_id;
    longint                got_count;
    logic [DROP_W-1:0]     drop_count;
    longint                byte_high_mark;
    logic [ID_W-1:0]       last_id;
    logic                  last_id_valid;
    logic [TICK_W-1:0]     idle_ticks;
    logic [MAX_SLICES-1:0] slice_marks;

    verdict_t expected_verdicts[$];
    int       fail_total = 0;

    // True when id a does not come after id b in 16-bit serial order.
    function automatic logic id_not_newer(input logic [ID_W-1:0] a, input logic [ID_W-1:0] b);
        logic [ID_W-1:0] diff;
        diff = a - b;
        return (diff == 0) || (diff >= 16'h8000);
    endfunction

    // A terminating verdict ends the current reassembly call.
    function automatic void close_call();
        in_frame       = 1'b0;
        got_count      = 0;
        drop_count     = '0;
        byte_high_mark = 0;
    endfunction

    // Works out the verdict of one request and advances the shadow state.
    // Returns 1 when the request yields a verdict.
    function automatic logic predict_verdict(
        input  logic [REQ_W-1:0]        req,
        input  logic                    peer,
        input  logic [ID_W-1:0]         fid,
        input  logic signed [RAW_W-1:0] raw_count,
        input  logic [DLEN_W-1:0]       dlen,
        output verdict_t                result
    );
        longint count_val;
        longint total;
        longint slice_limit;
        longint seq;
        longint size;
        longint pos;
        result = '0;
        if (req == REQ_TICK) begin
            if (idle_ticks != IDLE_MAX) idle_ticks = idle_ticks + 1'b1;
            if (last_id_valid && idle_ticks > resync_ticks) last_id_valid = 1'b0;
            return 1'b0;
        end
        if (req == REQ_END) begin
            close_call();
            result.verdict = V_END;
            return 1'b1;
        end
        if (req != REQ_HDR) return 1'b0;

        // From here on a datagram header; the early exits are errors unless marked.
        result.verdict = V_ERROR;
        if (buf_len == '0) begin
            close_call();
            return 1'b1;
        end
        if (!peer) begin
            result.verdict = V_DISCARD;
            return 1'b1;
        end
        if (int'(dlen) < HDR_BYTES || int'(dlen) > SLICE_BYTES + HDR_BYTES) begin
            close_call();
            return 1'b1;
        end
        count_val = raw_count;

        // A negative count opens a frame unless its id is stale or its count is out of range.
        if (count_val < 0) begin
            if ((in_frame && id_not_newer(fid, current_id)) ||
                (last_id_valid && id_not_newer(fid, last_id))) begin
                result.verdict = V_DISCARD;
                return 1'b1;
            end
            got_count  = 0;
            current_id = fid;
            if (raw_count == INT_MIN_BITS) begin
                close_call();
                return 1'b1;
            end
            total       = -count_val;
            slice_limit = (longint'(buf_len) - 1) / SLICE_BYTES + 1;
            if (slice_limit > MAX_SLICES) slice_limit = MAX_SLICES;
            if (total > slice_limit) begin
                close_call();
                return 1'b1;
            end
            slice_marks    = '0;
            in_frame       = 1'b1;
            expected_total = total;
            count_val      = total;
        end

        if (in_frame && fid != current_id) begin
            result.verdict = V_DISCARD;
            return 1'b1;
        end

        // Headers ahead of any start count toward the drop limit.
        if (!in_frame) begin
            drop_count = drop_count + 1'b1;
            if (drop_count < drop_limit) begin
                result.verdict = V_DISCARD;
                return 1'b1;
            end
            close_call();
            return 1'b1;
        end

        // Range, size and buffer fit of the slice.
        total = expected_total;
        if (count_val <= 0 || count_val > total) begin
            close_call();
            return 1'b1;
        end
        seq  = total - count_val;
        size = longint'(dlen) - HDR_BYTES;
        if (seq + 1 < total && size != SLICE_BYTES) begin
            close_call();
            return 1'b1;
        end
        pos = seq * SLICE_BYTES;
        if (size > longint'(buf_len) || pos > longint'(buf_len) - size || seq >= MAX_SLICES) begin
            close_call();
            return 1'b1;
        end
        if (slice_marks[int'(seq)]) begin
            result.verdict = V_DISCARD;
            return 1'b1;
        end

        // Store the slice and see whether the frame is whole.
        slice_marks[int'(seq)] = 1'b1;
        got_count = got_count + 1;
        if (pos + size > byte_high_mark) byte_high_mark = pos + size;
        result.write_offset = BYTE_W'(pos);
        result.write_len    = DLEN_W'(size);
        if (got_count >= total) begin
            result.verdict     = V_COMPLETE;
            result.frame_bytes = BYTE_W'(byte_high_mark);
            last_id            = current_id;
            last_id_valid      = 1'b1;
            idle_ticks         = '0;
            close_call();
            return 1'b1;
        end
        result.verdict = V_STORED;
        return 1'b1;
    endfunction

    // Reports one field that differs; returns the number of failures found.
    function automatic int field_mismatch(input string field, input logic [31:0] want,
                                          input logic [31:0] seen);
        if (want === seen) return 0;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
        return 1;
    endfunction

    // Track configuration writes, compare verdict transactions, predict requests.
    always @(posedge i_clk) begin
        verdict_t predicted;
        verdict_t seen;
        if (!i_rst_n) begin
            buf_len        = RST_BUF_LEN;
            drop_limit     = RST_DROP_LIMIT;
            resync_ticks   = RST_RESYNC;
            close_call();
            expected_total = 0;
            current_id     = '0;
            last_id        = '0;
            last_id_valid  = 1'b0;
            idle_ticks     = '0;
            slice_marks    = '0;
            expected_verdicts.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_BUF_LEN:    buf_len = i_cfg.data[BYTE_W-1:0];
                    CFG_DROP_LIMIT: drop_limit = i_cfg.data[DROP_W-1:0];
                    CFG_RESYNC:     resync_ticks = i_cfg.data[TICK_W-1:0];
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                seen = '{i_out.verdict, i_out.write_offset, i_out.write_len, i_out.frame_bytes};
                if (expected_verdicts.size() == 0) begin
                    $display("%0t: verdict transaction with none expected, expected none, actual %0d",
                             $time, seen.verdict);
                    fail_total++;
                end else begin
                    predicted = expected_verdicts.pop_front();
                    fail_total += field_mismatch("verdict", 32'(predicted.verdict),
                                                 32'(seen.verdict));
                    fail_total += field_mismatch("write_offset", 32'(predicted.write_offset),
                                                 32'(seen.write_offset));
                    fail_total += field_mismatch("write_len", 32'(predicted.write_len),
                                                 32'(seen.write_len));
                    fail_total += field_mismatch("frame_bytes", 32'(predicted.frame_bytes),
                                                 32'(seen.frame_bytes));
                end
            end
            if (i_in.valid && i_in.ready) begin
                if (predict_verdict(i_in.req_type, i_in.from_peer, i_in.frame_id,
                                    i_in.slice_count, i_in.datagram_len, predicted))
                    expected_verdicts.push_back(predicted);
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_verdicts.size();
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Top of the datagram frame reassembler testbench: clock, reset, request stimulus and verdict.
// Depends on dfr_pkg, dfr_channels, the reassembler unit and the dfr_checker module.
module tb_top;
    import dfr_pkg::*;

    localparam int MAX_SLICES      = 1024;
    localparam int SLICE_BYTES     = 1464;
    localparam int ITEMS_PER_PHASE = 260;
    localparam logic [DLEN_W-1:0] DGRAM_FULL = DLEN_W'(SLICE_BYTES + HDR_BYTES);

    // Request code that the block ignores.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dfr_in_if  in_ch();
    dfr_out_if out_ch();
    dfr_cfg_if cfg_ch();

    int fail_count;
    int pending_count;
    int tx_idle_pct = 38;
    int rx_idle_pct = 61;
    int sent_items  = 0;

    // Register values as last written, used to shape the frames.
    logic [BYTE_W-1:0] cur_buf_len    = RST_BUF_LEN;
    logic [DROP_W-1:0] cur_drop_limit = RST_DROP_LIMIT;
    logic [TICK_W-1:0] cur_resync     = RST_RESYNC;

    logic [ID_W-1:0] next_id;
    logic [ID_W-1:0] last_done_id;

    // 250 MHz clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    datagram_frame_reassembler_unit #(
        .MAX_SLICES (MAX_SLICES),
        .SLICE_BYTES(SLICE_BYTES)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch),
        .i_cfg  (cfg_ch)
    );

    dfr_checker #(
        .MAX_SLICES (MAX_SLICES),
        .SLICE_BYTES(SLICE_BYTES)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .i_cfg       (cfg_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending_count)
    );

    // Verdict receiver: stalls at random at the current idle rate.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= i_rst_n && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Slices the current buffer length allows in one frame.
    function automatic int frame_slice_limit();
        int lim;
        lim = (int'(cur_buf_len) - 1) / SLICE_BYTES + 1;
        return (lim > MAX_SLICES) ? MAX_SLICES : lim;
    endfunction

    // Offers one request and returns at the edge that accepts the transaction.
    task automatic send_req(input logic [REQ_W-1:0] req, input logic peer,
                            input logic [ID_W-1:0] fid, input logic [RAW_W-1:0] count,
                            input logic [DLEN_W-1:0] dlen);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.req_type     <= req;
        in_ch.from_peer    <= peer;
        in_ch.frame_id     <= fid;
        in_ch.slice_count  <= count;
        in_ch.datagram_len <= dlen;
        do @(posedge i_clk); while (!in_ch.ready);
        if (req != REQ_UNUSED) sent_items++;
    endtask

    task automatic send_hdr(input logic [ID_W-1:0] fid, input logic [RAW_W-1:0] count,
                            input logic [DLEN_W-1:0] dlen);
        send_req(REQ_HDR, 1'b1, fid, count, dlen);
    endtask

    // Stops sending until every expected verdict is in and the block has settled.
    task automatic wait_for_idle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input logic [BYTE_W-1:0] buf_bytes,
                                  input logic [DROP_W-1:0] drops,
                                  input logic [TICK_W-1:0] resync);
        wait_for_idle();
        write_reg(CFG_BUF_LEN, CFG_DATA_W'(buf_bytes));
        write_reg(CFG_DROP_LIMIT, CFG_DATA_W'(drops));
        write_reg(CFG_RESYNC, CFG_DATA_W'(resync));
        cur_buf_len    = buf_bytes;
        cur_drop_limit = drops;
        cur_resync     = resync;
    endtask

    // Sends one frame: the start slice first, then the rest in random order
    // with duplicates, foreign datagrams, ticks and other frames mixed in.
    task automatic send_frame(input logic [ID_W-1:0] fid, input int total);
        int order[$];
        int last_room;
        int last_size;
        int pick;
        int tmp;
        int seq;
        logic [DLEN_W-1:0] dlen;
        last_room = int'(cur_buf_len) - (total - 1) * SLICE_BYTES;
        if (last_room > SLICE_BYTES) last_room = SLICE_BYTES;
        last_size = $urandom_range(last_room);
        // Now and then a last slice that may overrun the buffer.
        if ($urandom_range(19) == 0) last_size = $urandom_range(SLICE_BYTES);
        for (int i = 1; i < total; i++) order.push_back(i);
        for (int i = order.size() - 1; i > 0; i--) begin
            pick        = $urandom_range(i);
            tmp         = order[i];
            order[i]    = order[pick];
            order[pick] = tmp;
        end
        dlen = DLEN_W'((total == 1) ? last_size + HDR_BYTES : DGRAM_FULL);
        send_hdr(fid, -total, dlen);
        foreach (order[k]) begin
            seq  = order[k];
            dlen = DLEN_W'((seq == total - 1) ? last_size + HDR_BYTES : DGRAM_FULL);
            case ($urandom_range(39))
                0: send_req(REQ_TICK, 1'b0, '0, '0, '0);
                1: send_req(REQ_HDR, 1'b0, fid, total - seq, dlen);
                2: send_hdr(fid + ID_W'($urandom_range(8, 1)), total - seq, dlen);
                3: return;
                default: ;
            endcase
            send_hdr(fid, total - seq, dlen);
            if ($urandom_range(14) == 0) send_hdr(fid, total - seq, dlen);
        end
    endtask

    // Stray and malformed requests.
    task automatic send_noise();
        int burst;
        logic [RAW_W-1:0] odd_count;
        case ($urandom_range(6))
            0: send_req(REQ_W'($urandom_range(3)), 1'($urandom_range(1)), ID_W'($urandom),
                        $urandom, DLEN_W'($urandom_range(2047)));
            1: begin
                // Enough ticks to forget the last frame when the resync time is short.
                burst = (cur_resync <= 40) ? $urandom_range(int'(cur_resync) + 2, 1)
                                           : $urandom_range(4, 1);
                repeat (burst) send_req(REQ_TICK, 1'($urandom_range(1)), ID_W'($urandom),
                                        $urandom, DLEN_W'($urandom_range(2047)));
            end
            2: send_req(REQ_END, 1'($urandom_range(1)), ID_W'($urandom), $urandom,
                        DLEN_W'($urandom_range(2047)));
            3: send_hdr(last_done_id, -$urandom_range(3, 1), DGRAM_FULL);
            4: begin
                // Slices with no start ahead of them.
                burst = $urandom_range((cur_drop_limit > 11) ? 12 : int'(cur_drop_limit) + 1, 1);
                repeat (burst) send_hdr(ID_W'($urandom), $urandom_range(5, 1), DGRAM_FULL);
            end
            5: begin
                if ($urandom_range(1) == 0) odd_count = 32'h8000_0000;
                else odd_count = -(frame_slice_limit() + $urandom_range(3, 1));
                next_id = next_id + 1'b1;
                send_hdr(next_id, odd_count, DGRAM_FULL);
            end
            default: begin
                case ($urandom_range(3))
                    0: odd_count = '0;
                    1: odd_count = 32'h7FFF_FFFF;
                    2: odd_count = 32'h0000_0001;
                    default: odd_count = 32'hFFFF_FFFF;
                endcase
                send_hdr(next_id, odd_count, DLEN_W'($urandom_range(2047)));
            end
        endcase
    endtask

    // One random phase: mostly whole frames, the rest stray requests.
    task automatic run_phase(input logic [BYTE_W-1:0] buf_bytes, input logic [DROP_W-1:0] drops,
                             input logic [TICK_W-1:0] resync, input int tx_pct, input int rx_pct);
        int target;
        int total;
        int lim;
        logic [ID_W-1:0] fid;
        apply_settings(buf_bytes, drops, resync);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        target = sent_items + ITEMS_PER_PHASE;
        while (sent_items < target) begin
            if ($urandom_range(99) < 65) begin
                lim = frame_slice_limit();
                if ($urandom_range(29) == 0) total = $urandom_range((lim > 40) ? 40 : lim, 1);
                else total = $urandom_range((lim > 6) ? 6 : lim, 1);
                if ($urandom_range(19) == 0) begin
                    fid = last_done_id - ID_W'($urandom_range(3));
                end else begin
                    next_id = next_id + ID_W'($urandom_range(3, 1));
                    fid     = next_id;
                end
                send_frame(fid, total);
                last_done_id = fid;
            end else begin
                send_noise();
            end
            if ($urandom_range(199) == 0) wait_for_idle();
        end
    endtask

    // Reset, directed requests, then the random phases and the verdict.
    initial begin
        in_ch.valid        = 1'b0;
        in_ch.req_type     = REQ_HDR;
        in_ch.from_peer    = 1'b0;
        in_ch.frame_id     = '0;
        in_ch.slice_count  = '0;
        in_ch.datagram_len = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = CFG_BUF_LEN;
        cfg_ch.data        = '0;
        i_rst_n            = 1'b0;
        next_id            = ID_W'($urandom);
        last_done_id       = next_id;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests at the reset settings.
        send_req(REQ_TICK, 1'b0, '0, '0, '0);
        send_req(REQ_UNUSED, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 11'h7FF);
        send_req(REQ_END, 1'b0, '0, '0, '0);
        send_req(REQ_HDR, 1'b0, 16'h1234, -1, DGRAM_FULL);
        send_hdr(16'h0010, -2, 11'd5);
        send_hdr(16'h0010, -2, DGRAM_FULL + DLEN_W'(1));
        send_hdr(16'h0010, 3, 11'h7FF);
        send_hdr(16'h0011, 32'h8000_0000, DGRAM_FULL);
        send_hdr(16'h0012, -(MAX_SLICES + 1), DGRAM_FULL);
        send_hdr(16'h0013, 3, DGRAM_FULL);
        // Largest frame: its last slice lands at the top of the buffer.
        send_hdr(16'hFFFE, -MAX_SLICES, DGRAM_FULL);
        send_hdr(16'hFFFE, 1, DGRAM_FULL);
        send_hdr(16'hFFFE, 1, DGRAM_FULL);
        send_hdr(16'h0005, 2, DGRAM_FULL);
        // A restart keeps the high mark, so this empty frame reports the full buffer.
        send_hdr(16'hFFFF, -1, DLEN_W'(HDR_BYTES));
        send_hdr(16'hFFFE, -2, DGRAM_FULL);
        send_hdr(16'h0001, -3, DGRAM_FULL);
        send_hdr(16'h0001, 4, DGRAM_FULL);
        send_hdr(16'h0002, -3, DGRAM_FULL);
        send_hdr(16'h0002, 2, 11'd1000);
        send_hdr(16'h0003, -2, DGRAM_FULL);
        send_hdr(16'h0003, 0, 11'd100);
        send_hdr(16'h0004, -2, DGRAM_FULL);
        send_hdr(16'h0004, 32'h7FFF_FFFF, DGRAM_FULL);

        // With no buffer every header is an error.
        apply_settings('0, RST_DROP_LIMIT, RST_RESYNC);
        send_hdr(16'h0020, -1, DGRAM_FULL);
        send_req(REQ_TICK, 1'b1, '0, '0, '0);

        run_phase(RST_BUF_LEN, 8'd16, 12'd5, 38, 61);
        run_phase(21'd1, 8'd1, 12'd1, 38, 61);
        run_phase(21'd5000, 8'd255, 12'd30, 61, 38);
        run_phase(BYTE_W'($urandom_range(20000, 1465)), DROP_W'($urandom_range(8, 2)),
                  TICK_W'($urandom_range(12, 3)), 61, 38);
        run_phase(RST_BUF_LEN, 8'd4, 12'd4095, 0, 0);

        wait_for_idle();
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog for a hung run.
    initial begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
